// File: design/aesctr_pkg.sv
// ----------------------------------------------------------------------------
// aesctr_pkg: shared types, constants and functions
// S-box table, GF(2^8) helpers and controller/datapath command types.
// ----------------------------------------------------------------------------
package aesctr_pkg;

    localparam int RK_DEPTH = 44;
    localparam int RK_AW    = 6;
    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] GF_POLY   = 8'h1B;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_IV_HIGH  = 2'd2;
    localparam logic [1:0] REG_IV_LOW   = 2'd3;

    localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};

    // controller -> datapath commands
    typedef struct packed {
        logic            ks_start;   // load key words 0..3, begin expansion
        logic            ks_step;    // compute next key word
        logic            blk_load;   // capture input, counter, initial add
        logic            rnd_step;   // one AES round
        logic            rnd_last;   // final round (no column mix)
        logic            out_load;   // form result word
        logic            rk_rd_en;   // read round key word
        logic [RK_AW-1:0] rk_rd_addr;
    } t_cmd;

    function automatic logic [7:0] xtime(input logic [7:0] b);
        xtime = {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// File: design/aesctr_if.sv
// ----------------------------------------------------------------------------
// aesctr_in_if / aesctr_out_if: valid/ready channels
// Input block word and result word channels.
// ----------------------------------------------------------------------------
interface aesctr_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  valid_bytes;
    logic        restart;
    modport source (output valid, data_high, data_low, valid_bytes, restart, input ready);
    modport sink   (input valid, data_high, data_low, valid_bytes, restart, output ready);
endinterface

interface aesctr_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  result_bytes;
    modport source (output valid, result_high, result_low, result_bytes, input ready);
    modport sink   (input valid, result_high, result_low, result_bytes, output ready);
endinterface

// File: design/aesctr_ram.sv
// ----------------------------------------------------------------------------
// aesctr_ram: generic single-port-write, registered-read RAM
// One write and one read port.
// ----------------------------------------------------------------------------
module aesctr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: design/aesctr_ctrl.sv
// ----------------------------------------------------------------------------
// aesctr_ctrl: sequencing controller
// Runs key expansion after reset or key writes, then block rounds.
// ----------------------------------------------------------------------------
module aesctr_ctrl
    import aesctr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_key_wr,
    input  logic i_in_valid,
    input  logic i_out_busy,
    output logic o_in_ready,
    output t_cmd o_cmd
);
    typedef enum logic [2:0] {S_KS_INIT, S_KS_RUN, S_IDLE, S_ROUND, S_OUT} t_state;

    t_state           r_state, n_state;
    logic [RK_AW-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == S_IDLE) && !i_key_wr;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_KS_INIT: begin
                o_cmd.ks_start = 1'b1;
                n_cnt   = RK_AW'(4);
                n_state = S_KS_RUN;
            end
            S_KS_RUN: begin
                // round key 0 is already written; keep it on the read port
                o_cmd.ks_step    = 1'b1;
                o_cmd.rk_rd_en   = 1'b1;
                o_cmd.rk_rd_addr = '0;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == RK_AW'(RK_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                // round key 0 is read ahead so it lands with the load
                o_cmd.rk_rd_en   = 1'b1;
                o_cmd.rk_rd_addr = '0;
                if (i_key_wr) begin
                    n_state = S_KS_INIT;
                end else if (i_in_valid && o_in_ready) begin
                    o_cmd.blk_load   = 1'b1;
                    o_cmd.rk_rd_addr = RK_AW'(1);
                    n_cnt   = RK_AW'(1);
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                // r_cnt = round number; its key words were read in the
                // prior cycle, the next round's words are read now
                o_cmd.rnd_step = 1'b1;
                o_cmd.rnd_last = (r_cnt == RK_AW'(10));
                if (r_cnt != RK_AW'(10)) begin
                    o_cmd.rk_rd_en   = 1'b1;
                    o_cmd.rk_rd_addr = r_cnt + 1'b1;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == RK_AW'(10)) n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free or draining
                o_cmd.rk_rd_en   = 1'b1;
                o_cmd.rk_rd_addr = '0;
                if (!i_out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_key_wr && r_state != S_IDLE) n_state = S_KS_INIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_KS_INIT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end
endmodule

// File: design/aesctr_dp.sv
// ----------------------------------------------------------------------------
// aesctr_dp: AES-128 CTR datapath
// Key schedule into a 44-word RAM (four banks of 11 round-key words),
// iterative round unit, counter and output word register.
// ----------------------------------------------------------------------------
module aesctr_dp
    import aesctr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic [63:0] i_data_high,
    input  logic [63:0] i_data_low,
    input  logic [4:0]  i_valid_bytes,
    input  logic        i_restart,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [63:0] o_result_high,
    output logic [63:0] o_result_low,
    output logic [4:0]  o_result_bytes
);
    localparam int BANK_DEPTH = RK_DEPTH / 4;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    logic [63:0]  r_key_high, r_key_low, r_iv_high, r_iv_low;
    logic [127:0] r_ctr;
    logic [127:0] r_state;
    logic [127:0] r_data;
    logic [4:0]   r_nbytes;
    logic [127:0] r_win;        // last four key words (sliding window)
    logic [7:0]   r_rc;
    logic [RK_AW-1:0] r_ks_idx;
    logic         r_out_valid;
    logic [63:0]  r_res_high, r_res_low;
    logic [4:0]   r_res_bytes;

    // ---------------- configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0; r_key_low <= '0; r_iv_high <= '0; r_iv_low <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_IV_HIGH:  r_iv_high  <= i_cfg_data;
                REG_IV_LOW:   r_iv_low   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- key schedule: one word per cycle
    logic [31:0] ks_t, ks_new;
    always_comb begin
        ks_t = r_win[31:0];
        if (r_ks_idx[1:0] == 2'd0)
            ks_t = sub_word({ks_t[23:0], ks_t[31:24]}) ^ {r_rc, 24'h0};
        ks_new = r_win[127:96] ^ ks_t;
    end

    logic [BANK_DEPTH*0+3:0] bank_we;
    logic [BANK_AW-1:0]      bank_waddr;
    logic [31:0]             bank_wdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ks_start) begin
            r_win    <= {r_key_high, r_key_low};
            r_rc     <= RCON_INIT;
            r_ks_idx <= RK_AW'(4);
        end else if (i_cmd.ks_step) begin
            r_win    <= {r_win[95:0], ks_new};
            r_ks_idx <= r_ks_idx + 1'b1;
            if (r_ks_idx[1:0] == 2'd0) r_rc <= xtime(r_rc);
        end
    end

    // words 0..3 written at start, then one word a step; bank = word % 4
    logic [3:0] bw_start;
    always_comb begin
        bank_we    = '0;
        bank_waddr = '0;
        bank_wdata = ks_new;
        bw_start   = '0;
        if (i_cmd.ks_step) begin
            bank_we[r_ks_idx[1:0]] = 1'b1;
            bank_waddr = BANK_AW'(r_ks_idx >> 2);
        end
        if (i_cmd.ks_start) bw_start = 4'hF;
    end

    logic [31:0] rk_word [4];
    logic [31:0] key_words [4];
    assign key_words[0] = r_key_high[63:32];
    assign key_words[1] = r_key_high[31:0];
    assign key_words[2] = r_key_low[63:32];
    assign key_words[3] = r_key_low[31:0];

    // round read address: round 0 while waiting, round 1 at the load,
    // then current round + 1
    logic [BANK_AW-1:0] rd_round;
    assign rd_round = BANK_AW'(i_cmd.rk_rd_addr);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        aesctr_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_ram (
            .i_clk   (i_clk),
            .i_we    (bank_we[b] | bw_start[b]),
            .i_waddr (bw_start[b] ? '0 : bank_waddr),
            .i_wdata (bw_start[b] ? key_words[b] : bank_wdata),
            .i_re    (i_cmd.rk_rd_en),
            .i_raddr (rd_round),
            .o_rdata (rk_word[b])
        );
    end

    logic [127:0] rk;
    assign rk = {rk_word[0], rk_word[1], rk_word[2], rk_word[3]};

    // ---------------- round unit
    logic [7:0]   sb [16];
    logic [127:0] sr, mc, rnd_out;
    always_comb begin
        for (int i = 0; i < 16; i++) sb[i] = SBOX[r_state[127-8*i -: 8]];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                sr[127-8*(4*c+r) -: 8] = sb[4*((c+r)%4)+r];
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = sr[127-32*c -: 8];   a1 = sr[119-32*c -: 8];
            a2 = sr[111-32*c -: 8];   a3 = sr[103-32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[127-32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            mc[119-32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            mc[111-32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            mc[103-32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        rnd_out = (i_cmd.rnd_last ? sr : mc) ^ rk;
    end

    logic [127:0] ctr_use;
    assign ctr_use = i_restart ? {r_iv_high, r_iv_low} : r_ctr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.blk_load) begin
            r_data   <= {i_data_high, i_data_low};
            r_nbytes <= (i_valid_bytes > 5'd16) ? 5'd16 : i_valid_bytes;
            r_state  <= ctr_use ^ rk;
        end else if (i_cmd.rnd_step) begin
            r_state  <= rnd_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)            r_ctr <= '0;
        else if (i_cmd.blk_load) r_ctr <= ctr_use + 128'd1;
    end

    // ---------------- output word
    logic [127:0] mask;
    always_comb begin
        for (int i = 0; i < 16; i++)
            mask[127-8*i -: 8] = (5'(i) < r_nbytes) ? 8'hFF : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            {r_res_high, r_res_low} <= (r_data ^ r_state) & mask;
            r_res_bytes <= r_nbytes;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_high  = r_res_high;
    assign o_result_low   = r_res_low;
    assign o_result_bytes = r_res_bytes;
endmodule

// File: design/aes128_ctr_keystream_xor.sv
// ----------------------------------------------------------------------------
// aes128_ctr_keystream_xor: AES-128 counter-mode combiner
// Controller plus datapath; one 16-byte word in, one word out.
// ----------------------------------------------------------------------------
// Each input word is XORed with AES-128 of the 128-bit big-endian counter,
// which then advances by one; restart reloads it from the IV first. Bytes past
// valid_bytes are zero (counts above 16 act as 16). From acceptance a block
// goes through the initial key addition at the accepting edge, then ten rounds
// of the shared round unit (round keys read in turn from the key RAM), then
// the forming of the result word. The next word can be taken in the cycle
// after the result is formed, so a word is not accepted while the one before
// is in flight; a result held by the receiver stalls only the forming of the
// result word of the following block. After reset or a key write the key
// schedule runs, one key word a cycle, while no word is accepted.
module aes128_ctr_keystream_xor
    import aesctr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    aesctr_in_if.sink   in_ch,
    aesctr_out_if.source out_ch
);
    t_cmd cmd;
    logic key_wr;
    logic in_ready;
    logic out_busy;

    assign key_wr = i_cfg_we &&
                    (i_cfg_idx == REG_KEY_HIGH || i_cfg_idx == REG_KEY_LOW);

    // output register holds a word that is not taken this cycle
    assign out_busy = out_ch.valid && !out_ch.ready;

    aesctr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key_wr   (key_wr),
        .i_in_valid (in_ch.valid),
        .i_out_busy (out_busy),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    assign in_ch.ready = in_ready;

    aesctr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_data_high    (in_ch.data_high),
        .i_data_low     (in_ch.data_low),
        .i_valid_bytes  (in_ch.valid_bytes),
        .i_restart      (in_ch.restart),
        .i_out_ready    (out_ch.ready),
        .o_out_valid    (out_ch.valid),
        .o_result_high  (out_ch.result_high),
        .o_result_low   (out_ch.result_low),
        .o_result_bytes (out_ch.result_bytes)
    );
endmodule
